### src/assert_macros.svh
// Assertion macros used by the RTL of the array list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### src/bale_pkg.sv
// Types and constants of the bounded array list engine.
package bale_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_UPDATE = 2'd3
  } cmd_t;

  localparam logic [4:0]        CAP_RESET  = 5'd16;
  localparam logic signed [4:0] FOUND_NONE = -5'sd1;

endpackage

### src/bounded_array_list_engine_unit.sv
// Bounded array list engine: append, remove-last, search and update on a list of words.
//
// Append, remove-last and update are executed in the cycle the request is
// accepted; the result then waits in S_HOLD until the output register is
// free and moves into it from there. A search reads the entries from
// position 0 upward through the single read port of the entry memory, one
// entry per cycle, and stops at the first hit or at the end of the list; the
// compare runs in the cycle after the read. The block accepts no request
// while one is in progress, but a new request is taken while the previous
// result still waits on the output register. Capacity is written through
// cfg_we and cfg_wdata; the user must write it only while the block is idle,
// which the block itself does not enforce. Values above DEPTH act as DEPTH.
module bounded_array_list_engine_unit
  import bale_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_value,
  input  logic [3:0]         in_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic signed [4:0]  out_found_index,
  output logic [4:0]         out_count
);

  `include "assert_macros.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t             state_r, state_nxt;
  logic [4:0]         cap_r, cap_nxt;
  logic [4:0]         length_r, length_nxt;
  logic [31:0]        value_r, value_nxt;
  logic [4:0]         issue_r, issue_nxt;
  logic               pend_r, pend_nxt;
  logic [4:0]         pend_i_r, pend_i_nxt;
  logic               res_ok_r, res_ok_nxt;
  logic signed [4:0]  res_found_r, res_found_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic signed [4:0]  out_found_r, out_found_nxt;
  logic [4:0]         out_count_r, out_count_nxt;

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [AW-1:0]      rd_addr;
  logic [4:0]         cap_lim;

  assign cap_lim = (32'(cap_r) > DEPTH) ? 5'(DEPTH) : cap_r;
  assign rd_addr = AW'(issue_r);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_index = out_found_r;
  assign out_count       = out_count_r;

  always_comb begin
    state_nxt     = state_r;
    cap_nxt       = cfg_we ? cfg_wdata : cap_r;
    length_nxt    = length_r;
    value_nxt     = value_r;
    issue_nxt     = issue_r;
    pend_nxt      = pend_r;
    pend_i_nxt    = pend_i_r;
    res_ok_nxt    = res_ok_r;
    res_found_nxt = res_found_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_found_nxt = out_found_r;
    out_count_nxt = out_count_r;
    mem_we        = 1'b0;
    mem_wa        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          value_nxt     = in_value;
          res_ok_nxt    = 1'b0;
          res_found_nxt = FOUND_NONE;
          state_nxt     = S_HOLD;
          case (cmd_t'(in_cmd))
            CMD_APPEND: begin
              if (length_r < cap_lim) begin
                mem_we     = 1'b1;
                mem_wa     = AW'(length_r);
                length_nxt = length_r + 5'd1;
                res_ok_nxt = 1'b1;
              end
            end
            CMD_REMOVE: begin
              if (length_r != 5'd0) begin
                length_nxt = length_r - 5'd1;
                res_ok_nxt = 1'b1;
              end
            end
            CMD_SEARCH: begin
              state_nxt = S_SCAN;
              issue_nxt = 5'd0;
              pend_nxt  = 1'b0;
            end
            CMD_UPDATE: begin
              if ({1'b0, in_index} < length_r) begin
                mem_we     = 1'b1;
                mem_wa     = AW'(in_index);
                res_ok_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = S_HOLD;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pend_r && (rd_data_r == value_r)) begin
          res_ok_nxt    = 1'b1;
          res_found_nxt = $signed(pend_i_r);
          state_nxt     = S_HOLD;
        end else if (!pend_r && (issue_r >= length_r)) begin
          state_nxt = S_HOLD;
        end else if (issue_r < length_r) begin
          issue_nxt  = issue_r + 5'd1;
          pend_nxt   = 1'b1;
          pend_i_nxt = issue_r;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_found_nxt = res_found_r;
          out_count_nxt = length_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_RESET;
      length_r    <= 5'd0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      length_r    <= length_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      value_r     <= value_nxt;
      issue_r     <= issue_nxt;
      pend_i_r    <= pend_i_nxt;
      res_ok_r    <= res_ok_nxt;
      res_found_r <= res_found_nxt;
      out_ok_r    <= out_ok_nxt;
      out_found_r <= out_found_nxt;
      out_count_r <= out_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_value;
    end
    rd_data_r <= mem[rd_addr];
  end

  `ASSERT_NEXT(a_append_grows, clk, rst_n,
    in_valid && in_ready && (cmd_t'(in_cmd) == CMD_APPEND) && (length_r < cap_lim),
    length_r == $past(length_r) + 5'd1)

  `ASSERT_NEXT(a_remove_shrinks, clk, rst_n,
    in_valid && in_ready && (cmd_t'(in_cmd) == CMD_REMOVE) && (length_r != 5'd0),
    length_r == $past(length_r) - 5'd1)

  `ASSERT_IMPLY(a_found_in_range, clk, rst_n,
    out_valid_r && (out_found_r != FOUND_NONE),
    out_ok_r && ($unsigned(out_found_r) < out_count_r))

endmodule
